### hdl/psus_pkg.sv
// Shared types and codes for the parity-split unique set.
// No dependencies; imported by psus_cell, parity_split_unique_set_top and tb.
package psus_pkg;

    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 6;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_SEARCH = 1'b1;

    // Search token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             odd;
        logic             hit;
        logic [VAL_W-1:0] value;
    } tok_t;

    // Append request broadcast to all cells
    typedef struct packed {
        logic             en;
        logic             odd;
        logic [VAL_W-1:0] value;
    } wr_t;

endpackage

### hdl/psus_cell.sv
// One cell of the set chain: holds entry POS of the even and the odd table.
// Depends on psus_pkg (tok_t, wr_t).
module psus_cell import psus_pkg::*; #(
    parameter int CNT_W = 7,
    parameter int IDX_W = 6,
    parameter int POS   = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  tok_t             tok_in,
    input  logic [IDX_W-1:0] idx_in,
    output tok_t             tok_out,
    output logic [IDX_W-1:0] idx_out,
    input  logic [CNT_W-1:0] even_cnt,
    input  logic [CNT_W-1:0] odd_cnt,
    input  wr_t              wr
);

    localparam logic [CNT_W-1:0] POS_C = CNT_W'(POS);
    localparam logic [IDX_W-1:0] POS_I = IDX_W'(POS);

    logic [VAL_W-1:0] even_entry_reg;
    logic [VAL_W-1:0] odd_entry_reg;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             in_use;
    logic             match;

    // The write always lands at the current end of the chosen table
    always_ff @(posedge aclk) begin
        if (wr.en && !wr.odd && even_cnt == POS_C) begin
            even_entry_reg <= wr.value;
        end
        if (wr.en && wr.odd && odd_cnt == POS_C) begin
            odd_entry_reg <= wr.value;
        end
    end

    always_comb begin
        in_use   = tok_in.odd ? (POS_C < odd_cnt) : (POS_C < even_cnt);
        match    = tok_in.valid && !tok_in.hit && in_use &&
                   ((tok_in.odd ? odd_entry_reg : even_entry_reg) == tok_in.value);
        tok_next = tok_in;
        idx_next = idx_in;
        if (match) begin
            tok_next.hit = 1'b1;
            idx_next     = POS_I;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg.valid <= 1'b0;
        end else begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
    end

    assign tok_out = tok_reg;
    assign idx_out = idx_reg;

endmodule

### hdl/parity_split_unique_set_top.sv
// Top level of the parity-split unique set: controller, counts and cell chain.
// Depends on psus_pkg and psus_cell.

// Two append-only sets of 32-bit values; bit 0 of a value picks the even or odd
// set. An insert (tuser 0) appends the value unless its set is full or already
// holds it; a search (tuser 1) returns the lowest index holding the value. Each
// request beat gives one result beat. Requests are handled one at a time: a
// request that needs a scan sends a token down a chain of CAPACITY cells, one
// cell per cycle; an insert into a full or empty set and a search of an empty
// set skip the chain. The result register lets the next request be accepted
// while a result waits to be taken.
module parity_split_unique_set_top import psus_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value (signed)
    input  logic        s_tuser,   // [0] kind: 0 insert, 1 search
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [2:0] status, [8:3] index, [15:9] zero
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CNT_W-1:0]    even_cnt_reg, even_cnt_next;
    logic [CNT_W-1:0]    odd_cnt_reg, odd_cnt_next;
    logic                launch_reg, launch_next;
    logic                kind_reg, kind_next;
    logic [VAL_W-1:0]    value_reg, value_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [INDEX_W-1:0]  res_index_reg, res_index_next;
    logic                res_write_reg, res_write_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [15:0]         m_tdata_reg, m_tdata_next;

    tok_t             tok_chain [0:CAPACITY];
    logic [IDX_W-1:0] idx_chain [0:CAPACITY];
    logic [CAPACITY:0] tok_vld;
    wr_t              wr;
    logic             s_beat;
    logic             in_odd;
    logic [CNT_W-1:0] in_cnt;
    logic             out_free;
    logic [IDX_W+INDEX_W-1:0] hit_idx_wide;

    assign s_tready = (state_reg == S_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign in_odd   = s_tdata[0];
    assign in_cnt   = in_odd ? odd_cnt_reg : even_cnt_reg;
    assign out_free = !m_tvalid_reg || m_tready;
    assign hit_idx_wide = {{INDEX_W{1'b0}}, idx_chain[CAPACITY]};

    assign tok_chain[0] = '{valid: launch_reg, odd: value_reg[0], hit: 1'b0,
                            value: value_reg};
    assign idx_chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            psus_cell #(
                .CNT_W (CNT_W),
                .IDX_W (IDX_W),
                .POS   (g)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .tok_in   (tok_chain[g]),
                .idx_in   (idx_chain[g]),
                .tok_out  (tok_chain[g+1]),
                .idx_out  (idx_chain[g+1]),
                .even_cnt (even_cnt_reg),
                .odd_cnt  (odd_cnt_reg),
                .wr       (wr)
            );
        end
        for (g = 0; g <= CAPACITY; g++) begin : g_vld
            assign tok_vld[g] = tok_chain[g].valid;
        end
    endgenerate

    always_comb begin
        state_next      = state_reg;
        even_cnt_next   = even_cnt_reg;
        odd_cnt_next    = odd_cnt_reg;
        launch_next     = 1'b0;
        kind_next       = kind_reg;
        value_next      = value_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        res_write_next  = res_write_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        wr.en           = 1'b0;
        wr.odd          = value_reg[0];
        wr.value        = value_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_beat) begin
                    kind_next      = s_tuser;
                    value_next     = s_tdata;
                    res_index_next = '0;
                    res_write_next = 1'b0;
                    if (s_tuser == KIND_INSERT && in_cnt == CAP_C) begin
                        res_status_next = ST_FULL;
                        state_next      = S_FIN;
                    end else if (in_cnt == '0) begin
                        // empty set: nothing to scan
                        if (s_tuser == KIND_INSERT) begin
                            res_status_next = ST_INSERTED;
                            res_write_next  = 1'b1;
                        end else begin
                            res_status_next = ST_EMPTY;
                        end
                        state_next = S_FIN;
                    end else begin
                        launch_next = 1'b1;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (tok_chain[CAPACITY].valid) begin
                    if (kind_reg == KIND_SEARCH) begin
                        res_status_next = tok_chain[CAPACITY].hit ? ST_FOUND : ST_NOTFOUND;
                        res_index_next  = tok_chain[CAPACITY].hit ?
                                          hit_idx_wide[INDEX_W-1:0] : '0;
                    end else if (tok_chain[CAPACITY].hit) begin
                        res_status_next = ST_DUPLICATE;
                    end else begin
                        res_status_next = ST_INSERTED;
                        res_write_next  = 1'b1;
                    end
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                // hold the result until the output register frees up
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, res_index_reg, res_status_reg};
                    wr.en         = res_write_reg;
                    if (res_write_reg) begin
                        if (value_reg[0]) begin
                            odd_cnt_next = odd_cnt_reg + 1'b1;
                        end else begin
                            even_cnt_next = even_cnt_reg + 1'b1;
                        end
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            even_cnt_reg <= '0;
            odd_cnt_reg  <= '0;
            launch_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            even_cnt_reg <= even_cnt_next;
            odd_cnt_reg  <= odd_cnt_next;
            launch_reg   <= launch_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg       <= kind_next;
        value_reg      <= value_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
        res_write_reg  <= res_write_next;
        m_tdata_reg    <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Only one request is ever in flight
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(tok_vld))
        else $error("more than one search token in the chain");

    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> !s_tready)
        else $error("request accepted while another is in progress");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        even_cnt_reg <= CAP_C && odd_cnt_reg <= CAP_C)
        else $error("set count beyond capacity");

    a_write_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |=> m_tvalid && m_tdata[STATUS_W-1:0] == ST_INSERTED)
        else $error("append without an inserted result");

endmodule

### tb/tb.sv
// Self-checking bench for parity_split_unique_set_top: directed and random requests.
// Keeps its own copy of both tables to predict each status/index beat.
// Depends on psus_pkg and the block's RTL.
module tb;
    import psus_pkg::*;

    localparam int CAPACITY     = 64;
    localparam int RANDOM_ITEMS = 1300;
    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
    } outcome_t;

    class split_set_scoreboard;
        logic [VAL_W-1:0] tables [2][CAPACITY];
        int unsigned      fill [2];
        outcome_t         pending_outcomes [$];
        int unsigned      errors;

        function new();
            fill[0] = 0;
            fill[1] = 0;
            errors  = 0;
        endfunction

        function int unsigned pending();
            return pending_outcomes.size();
        endfunction

        // Update the tables and queue the result this request must produce.
        function void predict_request(logic kind, logic [VAL_W-1:0] value);
            int       side;
            int       hit;
            outcome_t res;
            side = value[0];
            hit  = -1;
            res  = '0;
            for (int i = 0; i < fill[side]; i++) begin
                if (hit < 0 && tables[side][i] == value) begin
                    hit = i;
                end
            end
            if (kind == KIND_INSERT) begin
                if (fill[side] >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (hit >= 0) begin
                    res.status = ST_DUPLICATE;
                end else begin
                    tables[side][fill[side]] = value;
                    fill[side]++;
                    res.status = ST_INSERTED;
                end
            end else begin
                if (fill[side] == 0) begin
                    res.status = ST_EMPTY;
                end else if (hit >= 0) begin
                    res.status = ST_FOUND;
                    res.index  = hit[INDEX_W-1:0];
                end else begin
                    res.status = ST_NOTFOUND;
                end
            end
            pending_outcomes.push_back(res);
        endfunction

        function void check_response(logic [15:0] beat);
            outcome_t want;
            if (pending_outcomes.size() == 0) begin
                $error("result beat %h with nothing expected", beat);
                errors++;
                return;
            end
            want = pending_outcomes.pop_front();
            if (beat[2:0] !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, beat[2:0]);
                errors++;
            end
            if (beat[8:3] !== want.index) begin
                $error("index: expected %0d, got %0d", want.index, beat[8:3]);
                errors++;
            end
            if (beat[15:9] !== 7'd0) begin
                $error("pad: expected 0, got %h", beat[15:9]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    split_set_scoreboard sb;
    int unsigned         idle_pct;
    int unsigned         stall_pct;
    int unsigned         cycles;
    logic [VAL_W-1:0]    used_values [$];

    parity_split_unique_set_top #(.CAPACITY(CAPACITY)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk      = 1'b0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_INSERT;
        m_tready  = 1'b0;
        idle_pct  = 0;
        stall_pct = 0;
        cycles    = 0;
        sb        = new();
    end

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_response(m_tdata);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_request(input logic kind, input logic [VAL_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = value;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        sb.predict_request(kind, value);
        used_values.push_back(value);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Favor values already seen so duplicates and hits are common.
    function automatic logic [VAL_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45 && used_values.size() != 0) begin
            return used_values[$urandom_range(used_values.size() - 1)];
        end
        if (r < 55) begin
            case ($urandom_range(5))
                0: return 32'h0000_0000;
                1: return 32'h0000_0001;
                2: return 32'hFFFF_FFFF;
                3: return 32'hFFFF_FFFE;
                4: return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        return $urandom;
    endfunction

    initial begin
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // empty tables, first inserts, negatives and extremes
        send_request(KIND_SEARCH, 32'h0000_0000);
        send_request(KIND_SEARCH, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'h0000_0000);
        send_request(KIND_INSERT, 32'hFFFF_FFFE);
        send_request(KIND_INSERT, 32'h8000_0000);
        send_request(KIND_INSERT, 32'h7FFF_FFFF);
        send_request(KIND_INSERT, 32'hFFFF_FFFF);
        send_request(KIND_INSERT, 32'h0000_0001);
        send_request(KIND_INSERT, 32'h0000_0000);
        send_request(KIND_INSERT, 32'hFFFF_FFFF);
        send_request(KIND_SEARCH, 32'h8000_0000);
        send_request(KIND_SEARCH, 32'h0000_0000);
        send_request(KIND_SEARCH, 32'h0000_0001);
        send_request(KIND_SEARCH, 32'h0000_0002);
        send_request(KIND_SEARCH, 32'h0000_0003);
        send_request(KIND_INSERT, 32'hAAAA_AAAA);
        send_request(KIND_INSERT, 32'h5555_5555);
        send_request(KIND_SEARCH, 32'h5555_5555);
        send_request(KIND_SEARCH, 32'hFFFF_FFFE);
        send_request(KIND_SEARCH, 32'h7FFF_FFFF);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 49; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 49; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            for (int n = 0; n < RANDOM_ITEMS / 4; n++) begin
                send_request(($urandom_range(99) < 40) ? KIND_INSERT : KIND_SEARCH,
                             pick_value());
            end
            // hold off until every outstanding result is back
            drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
